>>> rtl/cb3mv_pkg.sv
package cb3mv_pkg;

  localparam int unsigned Lanes     = 8;
  localparam int unsigned NumLevels = 8;
  localparam int unsigned CodeW     = 3;
  localparam int unsigned GroupW    = Lanes * CodeW;
  localparam int unsigned LevelW    = 16;
  localparam int unsigned ActW      = 16;
  localparam int unsigned ProdW     = LevelW + ActW;
  localparam int unsigned GrpW      = 36;
  localparam int unsigned SumW      = 48;
  localparam int unsigned CfgIdxW   = 4;
  localparam int unsigned InDataW   = GroupW + Lanes * ActW;
  localparam int unsigned OutDataW  = SumW;

  localparam logic signed [SumW-1:0] SumMax = {1'b0, {(SumW-1){1'b1}}};
  localparam logic signed [SumW-1:0] SumMin = {1'b1, {(SumW-1){1'b0}}};

  typedef logic signed [LevelW-1:0] level_t;
  typedef logic signed [ProdW-1:0]  prod_t;

  // one group's partial sum on its way to the accumulator
  typedef struct packed {
    logic signed [GrpW-1:0] sum;
    logic                   last;
  } grp_t;

endpackage

>>> rtl/cb3mv_front.sv
module cb3mv_front (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [cb3mv_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [cb3mv_pkg::LevelW-1:0]    cfg_data_i,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [cb3mv_pkg::InDataW-1:0]   s_axis_tdata,
  input  logic                            s_axis_tlast,
  output logic                            grp_valid_o,
  input  logic                            grp_ready_i,
  output cb3mv_pkg::grp_t                 grp_o
);
  import cb3mv_pkg::*;

  level_t levels_q [NumLevels];

  logic  mul_v_q, mul_v_d;
  logic  mul_last_q;
  prod_t prod_q [Lanes];
  prod_t prod_d [Lanes];
  logic  mul_ready;

  logic  sum_v_q, sum_v_d;
  grp_t  sum_q;
  logic  sum_ready;

  logic signed [GrpW-1:0] pair_sum [Lanes/2];
  logic signed [GrpW-1:0] quad_sum [Lanes/4];
  logic signed [GrpW-1:0] grp_sum;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumLevels; i++) levels_q[i] <= '0;
    end else if (cfg_we_i && (cfg_idx_i < CfgIdxW'(NumLevels))) begin
      levels_q[cfg_idx_i[CodeW-1:0]] <= cfg_data_i;
    end
  end

  // lane k: level lookup by its code, times its activation
  always_comb begin
    for (int k = 0; k < Lanes; k++) begin
      prod_d[k] = levels_q[s_axis_tdata[k*CodeW +: CodeW]]
                * $signed(s_axis_tdata[GroupW + k*ActW +: ActW]);
    end
  end

  assign sum_ready     = !sum_v_q || grp_ready_i;
  assign mul_ready     = !mul_v_q || sum_ready;
  assign s_axis_tready = mul_ready;

  always_comb begin
    mul_v_d = mul_ready ? s_axis_tvalid : mul_v_q;
    sum_v_d = sum_ready ? mul_v_q : sum_v_q;
  end

  always_comb begin
    for (int i = 0; i < Lanes/2; i++) begin
      pair_sum[i] = GrpW'(prod_q[2*i]) + GrpW'(prod_q[2*i+1]);
    end
    for (int i = 0; i < Lanes/4; i++) begin
      quad_sum[i] = pair_sum[2*i] + pair_sum[2*i+1];
    end
    grp_sum = quad_sum[0] + quad_sum[1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_v_q <= 1'b0;
      sum_v_q <= 1'b0;
    end else begin
      mul_v_q <= mul_v_d;
      sum_v_q <= sum_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mul_ready && s_axis_tvalid) begin
      prod_q     <= prod_d;
      mul_last_q <= s_axis_tlast;
    end
    if (sum_ready && mul_v_q) begin
      sum_q.sum  <= grp_sum;
      sum_q.last <= mul_last_q;
    end
  end

  assign grp_valid_o = sum_v_q;
  assign grp_o       = sum_q;

endmodule

>>> rtl/cb3mv_fifo.sv
module cb3mv_fifo #(
  parameter int unsigned Depth = 4
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_valid_i,
  output logic            push_ready_o,
  input  cb3mv_pkg::grp_t push_data_i,
  output logic            pop_valid_o,
  input  logic            pop_ready_i,
  output cb3mv_pkg::grp_t pop_data_o
);
  import cb3mv_pkg::*;

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  grp_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            push, pop;

  assign push_ready_o = (cnt_q != CntW'(Depth));
  assign pop_valid_o  = (cnt_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    if (pop)  rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    if (push && !pop) cnt_d = cnt_q + 1'b1;
    else if (pop && !push) cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_ptr_q] <= push_data_i;
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(Depth))
    else $error("queue count over depth");

  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0 || cnt_q == CntW'(Depth)) |-> (wr_ptr_q == rd_ptr_q))
    else $error("queue pointers disagree with count");
`endif

endmodule

>>> rtl/cb3mv_back.sv
module cb3mv_back (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            grp_valid_i,
  output logic                            grp_ready_o,
  input  cb3mv_pkg::grp_t                 grp_i,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [cb3mv_pkg::OutDataW-1:0]  m_axis_tdata
);
  import cb3mv_pkg::*;

  logic signed [SumW-1:0] acc_q, acc_d;
  logic signed [SumW:0]   raw;
  logic signed [SumW-1:0] sat;
  logic                   out_v_q, out_v_d;
  logic [SumW-1:0]        out_q;
  logic                   out_free, pop;

  assign out_free    = !out_v_q || m_axis_tready;
  assign pop         = grp_valid_i && (!grp_i.last || out_free);
  assign grp_ready_o = !grp_i.last || out_free;

  always_comb begin
    raw = (SumW+1)'(acc_q) + (SumW+1)'(grp_i.sum);
    if (raw[SumW] != raw[SumW-1]) sat = raw[SumW] ? SumMin : SumMax;
    else sat = raw[SumW-1:0];
  end

  always_comb begin
    acc_d   = acc_q;
    out_v_d = out_v_q;
    if (m_axis_tready) out_v_d = 1'b0;
    if (pop) begin
      acc_d = grp_i.last ? '0 : sat;
      if (grp_i.last) out_v_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q   <= '0;
      out_v_q <= 1'b0;
    end else begin
      acc_q   <= acc_d;
      out_v_q <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop && grp_i.last) out_q <= sat;
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = out_q;

`ifndef SYNTHESIS
  a_row_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && grp_i.last) |=> (acc_q == '0))
    else $error("accumulator not cleared after row end");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && !m_axis_tready) |-> !(pop && grp_i.last))
    else $error("row sum loaded over a pending word");
`endif

endmodule

>>> rtl/codebook_3bit_matvec.sv
// A row's last word passes the product, sum, queue and output registers
// before it leaves on m_axis. Throughput: one word per cycle while m_axis
// is not stalled; eight lane multipliers and an accumulate step, with a
// group queue of FifoDepth entries between them. Reset (async, active
// low): levels and accumulator clear to zero, all stages and queue empty.
module codebook_3bit_matvec #(
  parameter int unsigned FifoDepth = 4
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [cb3mv_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [cb3mv_pkg::LevelW-1:0]    cfg_data_i,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // packed_group, act_0 .. act_7
  input  logic [cb3mv_pkg::InDataW-1:0]   s_axis_tdata,
  // row_last
  input  logic                            s_axis_tlast,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // row_sum
  output logic [cb3mv_pkg::OutDataW-1:0]  m_axis_tdata
);
  import cb3mv_pkg::*;

  logic f_valid, f_ready;
  grp_t f_data;
  logic b_valid, b_ready;
  grp_t b_data;

  cb3mv_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .grp_valid_o   (f_valid),
    .grp_ready_i   (f_ready),
    .grp_o         (f_data)
  );

  cb3mv_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (f_valid),
    .push_ready_o (f_ready),
    .push_data_i  (f_data),
    .pop_valid_o  (b_valid),
    .pop_ready_i  (b_ready),
    .pop_data_o   (b_data)
  );

  cb3mv_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .grp_valid_i   (b_valid),
    .grp_ready_o   (b_ready),
    .grp_i         (b_data),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

>>> verif/tb_codebook_3bit_matvec.sv
`timescale 1ns / 100ps

module tb_codebook_3bit_matvec;
  import cb3mv_pkg::*;

  localparam int unsigned Latency    = 3;
  localparam int unsigned MaxGap     = 15;
  localparam int unsigned HoldCycles = 300;
  localparam int unsigned NumPhases  = 4;
  localparam int unsigned PhaseWords = 150;
  localparam longint      CycleLimit = 400000;

  localparam logic [CfgIdxW-1:0] IdxLevel0 = '0;
  localparam logic [CfgIdxW-1:0] IdxUnused = CfgIdxW'(NumLevels);

  localparam logic [ActW-1:0]   ActMin   = 16'h8000;
  localparam logic [ActW-1:0]   ActMax   = 16'h7FFF;
  localparam logic [LevelW-1:0] LevelMax = 16'h7FFF;
  localparam logic [LevelW-1:0] EdgeLevels [NumLevels] = '{
    16'h8000, 16'h7FFF, 16'h0000, 16'h0001, 16'hFFFF, 16'h4000, 16'hC000, 16'h7FFE
  };

  class row_sum_scoreboard;
    level_t      levels [NumLevels];
    longint      acc;
    longint      sums_due [$];
    int unsigned errors;

    function new();
      foreach (levels[k]) levels[k] = '0;
      acc    = 0;
      errors = 0;
    endfunction

    function void set_level(logic [CfgIdxW-1:0] idx, logic [LevelW-1:0] value);
      if (idx < NumLevels) levels[idx] = value;
    endfunction

    function void note_word(logic [InDataW-1:0] data, logic last);
      logic [CodeW-1:0]       code;
      logic signed [ActW-1:0] act;
      longint                 total;
      total = acc;
      for (int k = 0; k < Lanes; k++) begin
        code  = data[k*CodeW +: CodeW];
        act   = data[GroupW + k*ActW +: ActW];
        total = total + longint'(levels[code]) * longint'(act);
      end
      if (total > longint'(SumMax)) total = longint'(SumMax);
      if (total < longint'(SumMin)) total = longint'(SumMin);
      if (last) begin
        sums_due.push_back(total);
        acc = 0;
      end else begin
        acc = total;
      end
    endfunction

    function void check_sum(logic [SumW-1:0] got);
      longint           exp;
      logic [SumW-1:0]  want;
      if (sums_due.size() == 0) begin
        $display("%0t: unexpected row_sum %0d", $realtime, $signed(got));
        errors++;
        return;
      end
      exp  = sums_due.pop_front();
      want = exp[SumW-1:0];
      if (got !== want) begin
        $display("%0t: row_sum expected %0d, got %0d", $realtime, exp, $signed(got));
        errors++;
      end
    endfunction

    function int unsigned pending();
      return sums_due.size();
    endfunction
  endclass

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 cfg_we_i      = 1'b0;
  logic [CfgIdxW-1:0]   cfg_idx_i     = '0;
  logic [LevelW-1:0]    cfg_data_i    = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [InDataW-1:0]   s_axis_tdata  = '0;
  logic                 s_axis_tlast  = 1'b0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [OutDataW-1:0]  m_axis_tdata;

  bit     tx_gaps     = 1'b0;
  bit     rx_gaps     = 1'b0;
  bit     rx_hold_req = 1'b0;
  longint cycles      = 0;

  row_sum_scoreboard sums = new();

  codebook_3bit_matvec dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready) sums.note_word(s_axis_tdata, s_axis_tlast);
    if (rst_ni && m_axis_tvalid && m_axis_tready) sums.check_sum(m_axis_tdata);
  end

  function automatic logic [15:0] pick16();
    case ($urandom_range(0, 7))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      3: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [InDataW-1:0] make_word(input logic [GroupW-1:0] group,
                                                   input logic [ActW-1:0] act);
    return {{Lanes{act}}, group};
  endfunction

  function automatic logic [InDataW-1:0] rand_word();
    logic [InDataW-1:0] w;
    w[GroupW-1:0] = GroupW'($urandom);
    for (int k = 0; k < Lanes; k++) w[GroupW + k*ActW +: ActW] = pick16();
    return w;
  endfunction

  task automatic send_word(input logic [InDataW-1:0] data, input logic last);
    int unsigned gap;
    gap = tx_gaps ? $urandom_range(0, MaxGap) : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tdata  = data;
    s_axis_tlast  = last;
    s_axis_tvalid = 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic write_level(input logic [CfgIdxW-1:0] idx, input logic [LevelW-1:0] value);
    @(negedge clk_i);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = value;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    sums.set_level(idx, value);
  endtask

  task automatic wait_results();
    while (sums.pending() != 0) @(posedge clk_i);
  endtask

  // open rows leave words in flight that owe no result
  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    wait_results();
    repeat (Latency + 2) @(posedge clk_i);
  endtask

  initial begin : sink
    int unsigned gap;
    wait (rst_ni);
    forever begin
      @(negedge clk_i);
      if (rx_hold_req) begin
        m_axis_tready = 1'b0;
        repeat (HoldCycles) @(negedge clk_i);
        rx_hold_req = 1'b0;
      end
      gap = rx_gaps ? $urandom_range(0, MaxGap) : 0;
      if (gap > 0) begin
        m_axis_tready = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      m_axis_tready = 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  initial begin : stimulus
    int unsigned      len;
    int unsigned      sent;
    bit               paused;
    logic [CodeW-1:0] code;

    repeat (3) @(negedge clk_i);
    rst_ni  = 1'b1;
    tx_gaps = 1'b1;
    rx_gaps = 1'b1;

    // levels still at reset
    send_word(make_word(24'hFFFFFF, ActMax), 1'b1);
    send_word(rand_word(), 1'b0);
    send_word(rand_word(), 1'b1);

    drain();
    for (int k = 0; k < NumLevels; k++) write_level(IdxLevel0 + CfgIdxW'(k), EdgeLevels[k]);
    write_level(IdxUnused + CfgIdxW'($urandom_range(0, 15 - NumLevels)), 16'($urandom));

    send_word(make_word(24'h000000, ActMin), 1'b1);
    send_word(make_word(24'hFAC688, ActMax), 1'b1);
    send_word(make_word(24'hFAC688, ActMin), 1'b1);
    send_word(make_word(24'hFAC688, 16'hFFFF), 1'b1);
    send_word(make_word(24'hFFFFFF, ActMin), 1'b1);
    send_word(make_word(24'h249249, ActMax), 1'b1);
    send_word(make_word(24'h000000, 16'h0000), 1'b1);
    for (int c = 0; c < NumLevels; c++) begin
      code = CodeW'(c);
      send_word(make_word({Lanes{code}}, pick16()), 1'b1);
    end
    send_word(rand_word(), 1'b0);
    send_word(rand_word(), 1'b0);
    send_word(rand_word(), 1'b1);

    for (int p = 0; p < NumPhases; p++) begin
      drain();
      tx_gaps = (p == 0 || p == 2);
      rx_gaps = (p == 0 || p == 3);
      for (int k = 0; k < NumLevels; k++)
        write_level(IdxLevel0 + CfgIdxW'(k), (p == 0) ? LevelMax : pick16());
      if (p == 3) write_level(IdxUnused + CfgIdxW'($urandom_range(0, 15 - NumLevels)),
                              16'($urandom));
      if (p == 1) rx_hold_req = 1'b1;
      sent   = 0;
      paused = 1'b0;
      while (sent < PhaseWords) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
        for (int i = 0; i < len; i++) begin
          send_word(rand_word(), i == len - 1);
          sent++;
        end
        if (p == 2 && !paused && sent >= PhaseWords / 2) begin
          paused = 1'b1;
          @(negedge clk_i);
          s_axis_tvalid = 1'b0;
          wait_results();
        end
      end
    end

    drain();
    if (sums.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
